// File: src/esvenc_pkg.sv
// shared types, constants and helpers of the escaped varint string encoder
package esvenc_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] ESC_BYTE  = 8'hFF;
  localparam logic [7:0] ESC_ZERO  = 8'h01;
  localparam logic [7:0] TAG_SHORT = 8'hFE;
  localparam logic [7:0] TAG_LONG  = 8'hFD;
  localparam logic [7:0] TERM_BYTE = 8'h00;

  typedef enum logic [1:0] {
    FMT_TERM = 2'd0,
    FMT_ONE  = 2'd1,
    FMT_TWO  = 2'd2,
    FMT_FOUR = 2'd3
  } fmt_e;

  typedef struct packed {
    fmt_e            fmt;
    logic [3:0][7:0] data;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic logic [1:0] last_idx(input fmt_e fmt);
    logic [1:0] idx;
    unique case (fmt)
      FMT_TWO:  idx = 2'd1;
      FMT_FOUR: idx = 2'd3;
      default:  idx = 2'd0;
    endcase
    return idx;
  endfunction

endpackage

// File: src/esvenc_front.sv
// front end: adds one to the word and classifies it into an encoding job
module esvenc_front import esvenc_pkg::*; (
  input  logic        kind_i,
  input  logic [31:0] value_i,
  output job_t        job_o
);

  logic [31:0] sum;

  assign sum = value_i + 32'd1;

  always_comb begin
    job_o.data = '0;
    if (kind_i) begin
      job_o.fmt = FMT_TERM;
    end else if (sum[31:8] == 24'd0) begin
      job_o.fmt     = FMT_ONE;
      job_o.data[0] = sum[7:0];
    end else if (sum[31:16] == 16'd0) begin
      job_o.fmt     = FMT_TWO;
      job_o.data[0] = sum[15:8];
      job_o.data[1] = sum[7:0];
    end else begin
      job_o.fmt     = FMT_FOUR;
      job_o.data[0] = sum[31:24];
      job_o.data[1] = sum[23:16];
      job_o.data[2] = sum[15:8];
      job_o.data[3] = sum[7:0];
    end
  end

endmodule

// File: src/esvenc_fifo.sv
// short job queue between the front end and the byte sequencer
module esvenc_fifo import esvenc_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  job_t       wdata_i,
  input  logic       pop_i,
  output job_t       rdata_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntFull);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: src/esvenc_back.sv
// back end: walks one job per pass and emits its bytes into the output register
module esvenc_back import esvenc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  fifo_stat_t stat_i,
  output logic       take_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  localparam logic [1:0] MARK_HEAD = 2'd0;
  localparam logic [1:0] MARK_TAG  = 2'd1;
  localparam logic [1:0] MARK_DONE = 2'd2;

  job_t       job_q, job_d;
  logic       busy_q, busy_d;
  logic [1:0] mark_q, mark_d;
  logic [1:0] bidx_q, bidx_d;
  logic       esc_q, esc_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       valid_q, valid_d;

  logic [7:0] cur_data, cur_byte;
  logic       marker_ph, at_last, needs_esc, done, emit;

  assign cur_data  = job_q.data[bidx_q];
  assign marker_ph = (job_q.fmt == FMT_TWO || job_q.fmt == FMT_FOUR) && (mark_q != MARK_DONE);
  assign at_last   = (bidx_q == last_idx(job_q.fmt));
  assign needs_esc = (cur_data == 8'h00) || (cur_data == ESC_BYTE);
  assign emit      = busy_q && (!valid_q || pop_i);

  always_comb begin
    cur_byte = cur_data;
    done     = 1'b0;
    priority if (job_q.fmt == FMT_TERM) begin
      cur_byte = TERM_BYTE;
      done     = 1'b1;
    end else if (marker_ph) begin
      if (mark_q == MARK_HEAD) begin
        cur_byte = ESC_BYTE;
      end else begin
        cur_byte = (job_q.fmt == FMT_TWO) ? TAG_SHORT : TAG_LONG;
      end
    end else if (esc_q) begin
      cur_byte = (cur_data == 8'h00) ? ESC_ZERO : ESC_BYTE;
      done     = at_last;
    end else if (needs_esc) begin
      cur_byte = ESC_BYTE;
    end else begin
      done = at_last;
    end
  end

  assign take_o = (!busy_q || (emit && done)) && !stat_i.empty;

  always_comb begin
    job_d   = job_q;
    busy_d  = busy_q;
    mark_d  = mark_q;
    bidx_d  = bidx_q;
    esc_d   = esc_q;
    byte_d  = byte_q;
    last_d  = last_q;
    valid_d = valid_q && !pop_i;
    if (emit) begin
      byte_d  = cur_byte;
      last_d  = done;
      valid_d = 1'b1;
      if (marker_ph && job_q.fmt != FMT_TERM) begin
        mark_d = mark_q + 1'b1;
      end else if (esc_q) begin
        esc_d  = 1'b0;
        bidx_d = bidx_q + 1'b1;
      end else if (needs_esc) begin
        esc_d = 1'b1;
      end else begin
        bidx_d = bidx_q + 1'b1;
      end
      if (done) begin
        busy_d = 1'b0;
      end
    end
    if (take_o) begin
      job_d  = job_i;
      busy_d = 1'b1;
      mark_d = MARK_HEAD;
      bidx_d = '0;
      esc_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    mark_q <= mark_d;
    bidx_q <= bidx_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      esc_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      esc_q   <= esc_d;
      valid_q <= valid_d;
    end
  end

  assign empty_o    = !valid_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;

  // escape second byte only follows a zero or all-ones data byte
  a_esc_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && esc_q |-> (cur_data == 8'h00 || cur_data == ESC_BYTE))
    else $error("escape pending on plain data byte");

  // final byte of a job carries the last flag
  a_last_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && done |=> valid_q && last_q)
    else $error("final beat lost its last flag");

  // inner bytes carry no last flag
  a_last_clr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !done |=> valid_q && !last_q && busy_q)
    else $error("inner beat flagged last or job dropped");

  // a new job is only taken once the current one is finished
  a_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && busy_q |-> emit && done)
    else $error("job replaced before its final beat");

endmodule

// File: src/escaped_varint_string_encoder_top.sv
// top level of the escaped varint string encoder
// Each accepted item becomes 1 to 10 output beats, one beat per cycle while the
// output register is empty or popped: a value item gives its data bytes (escape
// pairs for zero and all-ones bytes) behind a two-byte marker when the word plus
// one exceeds a byte, an end item gives one zero terminator. The back-end byte
// sequencer sets the rate, and it takes the next job from the queue in the same
// cycle as it emits the previous one's last byte, if the queue holds one. The front
// end takes one item per cycle while the job queue (FifoDepth entries) has room.
module escaped_varint_string_encoder_top import esvenc_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [31:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  job_t       front_job, queue_job;
  fifo_stat_t stat;
  logic       take;

  esvenc_front u_front (
    .kind_i  (kind_i),
    .value_i (value_i),
    .job_o   (front_job)
  );

  esvenc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_job),
    .pop_i   (take),
    .rdata_o (queue_job),
    .stat_o  (stat)
  );

  esvenc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (queue_job),
    .stat_i     (stat),
    .take_o     (take),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  assign full = stat.full;

endmodule

// File: tb/tb_escaped_varint_string_encoder_top.sv
// testbench of the escaped varint string encoder: queued stimulus, byte predictor, beat checker
module tb_escaped_varint_string_encoder_top import esvenc_pkg::*; ();

  localparam int unsigned HALF_HIGH      = 6;
  localparam int unsigned HALF_LOW       = 6;
  localparam int unsigned RAND_ITEMS     = 420;
  localparam int unsigned TAIL_ITEMS     = 60;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned TIMEOUT_CYCLES = 500000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct {
    logic        kind;
    logic [31:0] value;
  } word_item_t;

  typedef struct {
    logic [7:0] octet;
    logic       last;
  } enc_beat_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        push       = 1'b0;
  logic        kind_i     = 1'b0;
  logic [31:0] value_i    = 32'd0;
  logic        pop        = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte_o;
  logic        last_o;

  word_item_t  pending_words[$];
  enc_beat_t   expected_bytes[$];
  int unsigned mismatch_cnt = 0;
  int unsigned tx_gap       = 0;
  int unsigned rx_gap       = 0;

  escaped_varint_string_encoder_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  always begin
    #HALF_HIGH clk_i = 1'b1;
    #HALF_LOW  clk_i = 1'b0;
  end

  function automatic void add_word(input logic k, input logic [31:0] v);
    word_item_t w;
    w.kind  = k;
    w.value = v;
    pending_words.push_back(w);
  endfunction

  // expected byte string of one accepted item
  function automatic void encode_word(input logic k, input logic [31:0] v);
    logic [31:0] sum;
    logic [7:0]  seq[$];
    logic [7:0]  d;
    int          nbytes;
    enc_beat_t   b;
    sum = v + 32'd1;
    if (k) begin
      seq.push_back(TERM_BYTE);
    end else begin
      if (sum < 32'd256) begin
        nbytes = 1;
      end else if (sum < 32'd65536) begin
        nbytes = 2;
        seq.push_back(ESC_BYTE);
        seq.push_back(TAG_SHORT);
      end else begin
        nbytes = 4;
        seq.push_back(ESC_BYTE);
        seq.push_back(TAG_LONG);
      end
      for (int i = nbytes - 1; i >= 0; i--) begin
        d = sum[8*i +: 8];
        if (d == 8'h00) begin
          seq.push_back(ESC_BYTE);
          seq.push_back(ESC_ZERO);
        end else if (d == ESC_BYTE) begin
          seq.push_back(ESC_BYTE);
          seq.push_back(ESC_BYTE);
        end else begin
          seq.push_back(d);
        end
      end
    end
    foreach (seq[i]) begin
      b.octet = seq[i];
      b.last  = (i == seq.size() - 1);
      expected_bytes.push_back(b);
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push   <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (push && !full) begin
        encode_word(kind_i, value_i);
        void'(pending_words.pop_front());
      end
      if (!(push && full)) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          push   <= 1'b0;
        end else if (pending_words.size() == 0) begin
          push <= 1'b0;
        end else if (pending_words.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
          tx_gap <= $urandom_range(1, 14) - 1;
          push   <= 1'b0;
        end else begin
          push    <= 1'b1;
          kind_i  <= pending_words[0].kind;
          value_i <= pending_words[0].value;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop    <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected beat: byte %02h last %0b", out_byte_o, last_o);
        end else begin
          if (out_byte_o !== expected_bytes[0].octet || last_o !== expected_bytes[0].last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("beat mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       expected_bytes[0].octet, expected_bytes[0].last, out_byte_o, last_o);
          end
          void'(expected_bytes.pop_front());
        end
      end
      if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        pop    <= 1'b0;
      end else if (pending_words.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
        rx_gap <= $urandom_range(1, 14) - 1;
        pop    <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] sum;
    logic [7:0]  pick;
    int unsigned r;

    // end items, value ignored
    add_word(1'b1, 32'h0000_0000);
    add_word(1'b1, 32'hFFFF_FFFF);
    add_word(1'b1, 32'hA5A5_5A5A);
    // all-ones wraps to zero
    add_word(1'b0, 32'hFFFF_FFFF);
    add_word(1'b0, 32'h0000_0000);
    add_word(1'b0, 32'h0000_00FD);
    add_word(1'b0, 32'h0000_00FE);
    add_word(1'b0, 32'h0000_00FF);
    add_word(1'b0, 32'h0000_0100);
    add_word(1'b0, 32'h0000_FEFE);
    add_word(1'b0, 32'h0000_FEFF);
    add_word(1'b0, 32'h0000_FFFE);
    add_word(1'b0, 32'h0000_FFFF);
    add_word(1'b0, 32'h00FF_FFFF);
    add_word(1'b0, 32'hFF00_FEFF);
    add_word(1'b0, 32'hFFFF_FFFE);
    add_word(1'b0, 32'hFEFF_FFFF);
    add_word(1'b0, 32'h7FFF_FFFF);
    add_word(1'b0, 32'h5555_5555);
    add_word(1'b0, 32'hAAAA_AAAA);
    add_word(1'b1, 32'h0000_0001);
    add_word(1'b0, 32'h0000_0001);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        add_word(1'b1, $urandom());
      end else begin
        case ($urandom_range(0, 4))
          0: add_word(1'b0, $urandom_range(0, 300));
          1: add_word(1'b0, $urandom_range(200, 70000));
          2: add_word(1'b0, $urandom());
          default: begin
            for (int i = 0; i < 4; i++) begin
              case ($urandom_range(0, 4))
                0: pick = 8'h00;
                1: pick = 8'hFF;
                2: pick = 8'h01;
                3: pick = 8'hFE;
                default: pick = 8'($urandom_range(0, 255));
              endcase
              sum[8*i +: 8] = pick;
            end
            add_word(1'b0, sum - 32'd1);
          end
        endcase
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || push || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_bytes.size() == 0) begin
      $display("escaped_varint_string_encoder_top: match");
    end else begin
      $display("escaped_varint_string_encoder_top: mismatch");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * (HALF_HIGH + HALF_LOW));
    $display("escaped_varint_string_encoder_top: mismatch");
    $finish;
  end

endmodule
